[design/cbo_pkg.sv]
// cbo_pkg: shared types and constants of the camera basis block.
// No dependencies; imported by every module of the block.
package cbo_pkg;

   localparam int COMP_W      = 32;
   localparam int VEC_ID_W    = 3;
   localparam int DIM_W       = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int MAG_W       = 64;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_HEIGHT = 2'd1;

   localparam logic [DIM_W-1:0] WINDOW_WIDTH_RESET  = 14'd1024;
   localparam logic [DIM_W-1:0] WINDOW_HEIGHT_RESET = 14'd768;

   // vector codes, in emission order
   localparam logic [VEC_ID_W-1:0] VEC_NEAR  = 3'd0;
   localparam logic [VEC_ID_W-1:0] VEC_RIGHT = 3'd1;
   localparam logic [VEC_ID_W-1:0] VEC_LEFT  = 3'd2;
   localparam logic [VEC_ID_W-1:0] VEC_UP    = 3'd3;
   localparam logic [VEC_ID_W-1:0] VEC_BACK  = 3'd4;

   typedef struct packed {
      logic signed [COMP_W-1:0] offset_x;
      logic signed [COMP_W-1:0] offset_y;
      logic signed [COMP_W-1:0] offset_z;
   } req_type;

   typedef struct packed {
      logic [VEC_ID_W-1:0]      vector_id;
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic                     degenerate;
      logic                     last;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      req_type offset;
      logic    degenerate;
   } job_type;

   // request to the normalization unit: magnitudes and signs of three components
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
   } unit_req_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

endpackage

[design/cbo_front.sv]
// cbo_front: input register stage; accepts offsets and flags degenerate ones.
// Depends on cbo_pkg.
module cbo_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbo_pkg::req_type  req_data,
   output logic              push_valid,
   output cbo_pkg::job_type  push_data,
   input  logic              push_ready
);
   import cbo_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    accept;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_data  = job_ff;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (accept) begin
         valid_in            = 1'b1;
         job_in.offset       = req_data;
         // on the z axis or at the origin: no basis exists
         job_in.degenerate   = (req_data.offset_x == '0) && (req_data.offset_y == '0);
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

[design/cbo_queue.sv]
// cbo_queue: short FIFO of classified items between front and back.
// Depends on cbo_pkg.
module cbo_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cbo_pkg::job_type  push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output cbo_pkg::job_type  pop_data,
   input  logic              pop_ready
);
   import cbo_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/cbo_unitize.sv]
// cbo_unitize: shared multi-cycle vector normalizer (shift, square sum,
// bit-serial square root, three bit-serial dividers). Depends on cbo_pkg.
module cbo_unitize #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  cbo_pkg::unit_req_type        unit_req,
   output logic                         done,
   output logic signed [FRAC_BITS+1:0]  quot [3]
);
   import cbo_pkg::*;

   localparam int DCNT_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [5:0] {
      U_IDLE = 6'b000001,
      U_NORM = 6'b000010,
      U_SQ   = 6'b000100,
      U_SQRT = 6'b001000,
      U_DIV  = 6'b010000,
      U_DONE = 6'b100000
   } ustate_type;

   ustate_type          state_ff, state_in;
   logic [MAG_W-1:0]    mag_ff [3];
   logic [MAG_W-1:0]    mag_in [3];
   logic [2:0]          neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [MAG_W-1:0]    acc_ff, acc_in;
   logic [MAG_W-1:0]    res_ff, res_in;
   logic [MAG_W-1:0]    bit_ff, bit_in;
   logic [31:0]         rem_ff [3];
   logic [31:0]         rem_in [3];
   logic [FRAC_BITS:0]  q_ff [3];
   logic [FRAC_BITS:0]  q_in [3];
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;

   logic                any_ge39, any_ge31, all_lt22, all_lt30;
   logic [30:0]         sq_op;
   logic [61:0]         sq;
   logic [MAG_W-1:0]    sqrt_trial;
   logic [32:0]         div_trial [3];

   always_comb begin
      any_ge39 = 1'b0;
      any_ge31 = 1'b0;
      all_lt22 = 1'b1;
      all_lt30 = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i][MAG_W-1:39] != '0) any_ge39 = 1'b1;
         if (mag_ff[i][MAG_W-1:31] != '0) any_ge31 = 1'b1;
         if (mag_ff[i][MAG_W-1:22] != '0) all_lt22 = 1'b0;
         if (mag_ff[i][MAG_W-1:30] != '0) all_lt30 = 1'b0;
      end
      sq_op      = mag_ff[cnt_ff][30:0];
      sq         = sq_op * sq_op;
      sqrt_trial = res_ff + bit_ff;
      for (int i = 0; i < 3; i++) begin
         div_trial[i] = (dcnt_ff == '0) ? {1'b0, rem_ff[i]} : {rem_ff[i], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) mag_in[i] = unit_req.mag[i];
               neg_in   = unit_req.neg;
               zero_in  = (unit_req.mag == '0);
               state_in = (unit_req.mag == '0) ? U_DONE : U_NORM;
            end
         end
         U_NORM: begin
            // bring the largest magnitude into [2^30, 2^31)
            if (any_ge39) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 8;
            end else if (any_ge31) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (all_lt22) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 8;
            end else if (all_lt30) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            acc_in = acc_ff + {2'b00, sq};
            if (cnt_ff == 2'd2) begin
               res_in   = '0;
               bit_in   = MAG_W'(1) << 62;
               state_in = U_SQRT;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         U_SQRT: begin
            if (acc_ff >= sqrt_trial) begin
               acc_in = acc_ff - sqrt_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               for (int i = 0; i < 3; i++) begin
                  rem_in[i] = {1'b0, mag_ff[i][30:0]};
                  q_in[i]   = '0;
               end
               dcnt_in  = '0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (div_trial[i] >= {1'b0, res_ff[31:0]}) begin
                  rem_in[i] = 32'(div_trial[i] - {1'b0, res_ff[31:0]});
                  q_in[i]   = {q_ff[i][FRAC_BITS-1:0], 1'b1};
               end else begin
                  rem_in[i] = div_trial[i][31:0];
                  q_in[i]   = {q_ff[i][FRAC_BITS-1:0], 1'b0};
               end
            end
            dcnt_in = DCNT_W'(dcnt_ff + 1'b1);
            if (dcnt_ff == DCNT_W'(FRAC_BITS)) state_in = U_DONE;
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   assign done = (state_ff == U_DONE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zero_ff) begin
            quot[i] = '0;
         end else if (neg_ff[i]) begin
            quot[i] = -$signed({1'b0, q_ff[i]});
         end else begin
            quot[i] = $signed({1'b0, q_ff[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

[design/cbo_back.sv]
// cbo_back: sequencer that builds near, right and up through the shared
// normalizer, scales up by the aspect ratio and emits five items.
// Depends on cbo_pkg and cbo_unitize.
module cbo_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  cbo_pkg::job_type  job,
   output logic              job_pop,
   input  cbo_pkg::dims_type dims,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbo_pkg::rsp_type  rsp_data
);
   import cbo_pkg::*;

   localparam int QW     = FRAC_BITS + 2;
   localparam int PRW    = 2 * QW;
   localparam int PW     = FRAC_BITS + 1 + DIM_W;
   localparam int SCNT_W = $clog2(PW);

   typedef enum logic [11:0] {
      B_IDLE       = 12'b000000000001,
      B_NEAR_GO    = 12'b000000000010,
      B_NEAR_WAIT  = 12'b000000000100,
      B_RIGHT_GO   = 12'b000000001000,
      B_RIGHT_WAIT = 12'b000000010000,
      B_CROSS_A    = 12'b000000100000,
      B_CROSS_B    = 12'b000001000000,
      B_UP_GO      = 12'b000010000000,
      B_UP_WAIT    = 12'b000100000000,
      B_SCALE_MUL  = 12'b001000000000,
      B_SCALE_DIV  = 12'b010000000000,
      B_EMIT       = 12'b100000000000
   } bstate_type;

   bstate_type               state_ff, state_in;
   job_type                  job_ff, job_in;
   logic signed [QW-1:0]     near_ff [3];
   logic signed [QW-1:0]     near_in [3];
   logic signed [QW-1:0]     right_ff [3];
   logic signed [QW-1:0]     right_in [3];
   logic signed [QW-1:0]     up_ff [3];
   logic signed [QW-1:0]     up_in [3];
   logic signed [PRW-1:0]    pa_ff [3];
   logic signed [PRW-1:0]    pa_in [3];
   logic signed [PRW-1:0]    pb_ff [3];
   logic signed [PRW-1:0]    pb_in [3];
   logic [PW-1:0]            dvd_ff [3];
   logic [PW-1:0]            dvd_in [3];
   logic [DIM_W-1:0]         srem_ff [3];
   logic [DIM_W-1:0]         srem_in [3];
   logic [PW-1:0]            squot_ff [3];
   logic [PW-1:0]            squot_in [3];
   logic [2:0]               sneg_ff, sneg_in;
   logic [SCNT_W-1:0]        scnt_ff, scnt_in;
   logic [VEC_ID_W-1:0]      k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     unit_start, unit_done;
   unit_req_type             unit_req;
   logic signed [QW-1:0]     unit_quot [3];

   logic [DIM_W-1:0]         width_eff;
   logic                     out_free;
   logic signed [63:0]       up_wide [3];
   logic signed [COMP_W-1:0] up_sat [3];
   logic signed [COMP_W-1:0] back_sat [3];

   function automatic logic signed [COMP_W-1:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[COMP_W-1:0];
   endfunction

   function automatic logic [32:0] abs32(input logic signed [COMP_W-1:0] x);
      return x[COMP_W-1] ? (33'd0 - 33'(x)) : 33'(x);
   endfunction

   cbo_unitize #(.FRAC_BITS(FRAC_BITS)) u_unitize (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .unit_req (unit_req),
      .done     (unit_done),
      .quot     (unit_quot)
   );

   assign width_eff = (dims.width == '0) ? DIM_W'(1) : dims.width;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign job_pop   = (state_ff == B_IDLE) && job_valid;
   assign unit_start = (state_ff == B_NEAR_GO) || (state_ff == B_RIGHT_GO) ||
                       (state_ff == B_UP_GO);

   // request to the normalizer, by pass
   always_comb begin
      logic signed [PRW:0] tdiff;
      logic [PRW:0]        tabs;
      tdiff    = '0;
      tabs     = '0;
      unit_req = '0;
      unique case (state_ff)
         B_NEAR_GO: begin
            // near = unit(-v)
            unit_req.mag[0] = MAG_W'(abs32(job_ff.offset.offset_x));
            unit_req.mag[1] = MAG_W'(abs32(job_ff.offset.offset_y));
            unit_req.mag[2] = MAG_W'(abs32(job_ff.offset.offset_z));
            unit_req.neg[0] = job_ff.offset.offset_x > 0;
            unit_req.neg[1] = job_ff.offset.offset_y > 0;
            unit_req.neg[2] = job_ff.offset.offset_z > 0;
         end
         B_RIGHT_GO: begin
            // right = unit(-v.y, v.x, 0)
            unit_req.mag[0] = MAG_W'(abs32(job_ff.offset.offset_y));
            unit_req.mag[1] = MAG_W'(abs32(job_ff.offset.offset_x));
            unit_req.neg[0] = job_ff.offset.offset_y > 0;
            unit_req.neg[1] = job_ff.offset.offset_x < 0;
         end
         B_UP_GO: begin
            for (int i = 0; i < 3; i++) begin
               tdiff = (PRW+1)'(pa_ff[i]) - (PRW+1)'(pb_ff[i]);
               tabs  = tdiff[PRW] ? (PRW+1)'(-tdiff) : tdiff;
               unit_req.mag[i] = MAG_W'(tabs);
               unit_req.neg[i] = tdiff[PRW];
            end
         end
         default: begin
            unit_req = '0;
         end
      endcase
   end

   always_comb begin
      logic signed [PW:0] scaled;
      for (int i = 0; i < 3; i++) begin
         scaled      = sneg_ff[i] ? -$signed({1'b0, squot_ff[i]}) : $signed({1'b0, squot_ff[i]});
         up_wide[i]  = 64'(scaled);
         up_sat[i]   = sat32(up_wide[i]);
         back_sat[i] = sat32(-up_wide[i]);
      end
   end

   always_comb begin
      logic [FRAC_BITS:0] up_abs;
      logic [DIM_W:0]     strial;
      up_abs       = '0;
      strial       = '0;
      state_in     = state_ff;
      job_in       = job_ff;
      near_in      = near_ff;
      right_in     = right_ff;
      up_in        = up_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      dvd_in       = dvd_ff;
      srem_in      = srem_ff;
      squot_in     = squot_ff;
      sneg_in      = sneg_ff;
      scnt_in      = scnt_ff;
      k_in         = k_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               k_in     = VEC_NEAR;
               state_in = job.degenerate ? B_EMIT : B_NEAR_GO;
            end
         end
         B_NEAR_GO:  state_in = B_NEAR_WAIT;
         B_NEAR_WAIT: begin
            if (unit_done) begin
               near_in  = unit_quot;
               state_in = B_RIGHT_GO;
            end
         end
         B_RIGHT_GO: state_in = B_RIGHT_WAIT;
         B_RIGHT_WAIT: begin
            if (unit_done) begin
               right_in = unit_quot;
               state_in = B_CROSS_A;
            end
         end
         B_CROSS_A: begin
            pa_in[0] = right_ff[1] * near_ff[2];
            pa_in[1] = right_ff[2] * near_ff[0];
            pa_in[2] = right_ff[0] * near_ff[1];
            state_in = B_CROSS_B;
         end
         B_CROSS_B: begin
            pb_in[0] = right_ff[2] * near_ff[1];
            pb_in[1] = right_ff[0] * near_ff[2];
            pb_in[2] = right_ff[1] * near_ff[0];
            state_in = B_UP_GO;
         end
         B_UP_GO:    state_in = B_UP_WAIT;
         B_UP_WAIT: begin
            if (unit_done) begin
               up_in    = unit_quot;
               state_in = B_SCALE_MUL;
            end
         end
         B_SCALE_MUL: begin
            for (int i = 0; i < 3; i++) begin
               up_abs      = up_ff[i][QW-1] ? (FRAC_BITS+1)'(0) - up_ff[i][FRAC_BITS:0]
                                            : up_ff[i][FRAC_BITS:0];
               sneg_in[i]  = up_ff[i][QW-1];
               dvd_in[i]   = up_abs * dims.height;
               srem_in[i]  = '0;
               squot_in[i] = '0;
            end
            scnt_in  = '0;
            state_in = B_SCALE_DIV;
         end
         B_SCALE_DIV: begin
            // one quotient bit per lane per cycle, magnitude / width
            for (int i = 0; i < 3; i++) begin
               strial = {srem_ff[i], dvd_ff[i][PW-1]};
               if (strial >= {1'b0, width_eff}) begin
                  srem_in[i]  = DIM_W'(strial - {1'b0, width_eff});
                  squot_in[i] = {squot_ff[i][PW-2:0], 1'b1};
               end else begin
                  srem_in[i]  = strial[DIM_W-1:0];
                  squot_in[i] = {squot_ff[i][PW-2:0], 1'b0};
               end
               dvd_in[i] = dvd_ff[i] << 1;
            end
            scnt_in = SCNT_W'(scnt_ff + 1'b1);
            if (scnt_ff == SCNT_W'(PW - 1)) begin
               k_in     = VEC_NEAR;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.vector_id  = k_ff;
               rsp_data_in.degenerate = job_ff.degenerate;
               rsp_data_in.last       = (k_ff == VEC_BACK);
               unique case (k_ff)
                  VEC_NEAR: begin
                     rsp_data_in.comp_x = COMP_W'(near_ff[0]);
                     rsp_data_in.comp_y = COMP_W'(near_ff[1]);
                     rsp_data_in.comp_z = COMP_W'(near_ff[2]);
                  end
                  VEC_RIGHT: begin
                     rsp_data_in.comp_x = COMP_W'(right_ff[0]);
                     rsp_data_in.comp_y = COMP_W'(right_ff[1]);
                     rsp_data_in.comp_z = COMP_W'(right_ff[2]);
                  end
                  VEC_LEFT: begin
                     rsp_data_in.comp_x = -COMP_W'(right_ff[0]);
                     rsp_data_in.comp_y = -COMP_W'(right_ff[1]);
                     rsp_data_in.comp_z = -COMP_W'(right_ff[2]);
                  end
                  VEC_UP: begin
                     rsp_data_in.comp_x = up_sat[0];
                     rsp_data_in.comp_y = up_sat[1];
                     rsp_data_in.comp_z = up_sat[2];
                  end
                  VEC_BACK: begin
                     rsp_data_in.comp_x = back_sat[0];
                     rsp_data_in.comp_y = back_sat[1];
                     rsp_data_in.comp_z = back_sat[2];
                  end
                  default: begin
                     rsp_data_in.comp_x = '0;
                     rsp_data_in.comp_y = '0;
                     rsp_data_in.comp_z = '0;
                  end
               endcase
               if (job_ff.degenerate) begin
                  rsp_data_in.comp_x = '0;
                  rsp_data_in.comp_y = '0;
                  rsp_data_in.comp_z = '0;
               end
               if (k_ff == VEC_BACK) begin
                  state_in = B_IDLE;
               end else begin
                  k_in = VEC_ID_W'(k_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      near_ff     <= near_in;
      right_ff    <= right_in;
      up_ff       <= up_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      dvd_ff      <= dvd_in;
      srem_ff     <= srem_in;
      squot_ff    <= squot_in;
      sneg_ff     <= sneg_in;
      scnt_ff     <= scnt_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[design/camera_basis_from_offset.sv]
// camera_basis_from_offset: top level; window registers, front, queue, back.
// Depends on cbo_pkg, cbo_front, cbo_queue, cbo_back.
//
// Takes a signed fixed-point camera offset per item and returns a run of five
// items: near, right, left, up (scaled by height/width) and back, tagged by
// vector_id, with last set on back. Offsets with zero x and y give five zero
// vectors flagged degenerate. Items enter through a register stage and a
// two-entry queue, so new offsets are taken while a run is being computed or
// is waiting on rsp_stall. The back end takes a normal item in a pick-up
// state, normalizes near and right, forms the cross product in B_CROSS_A and
// B_CROSS_B, normalizes up, scales up by height/width with a multiply state
// and a bit-serial divide, and emits the five outputs. Each normalization
// has a start state, the scaling shifts, the sum of squares, the bit-serial
// square root, the dividers and a done state. A degenerate item goes from
// pick-up straight to the five outputs.
// The window registers are written through csr_write/csr_index/csr_data and
// should be changed only while the block is idle; a width of zero acts as one.
module camera_basis_from_offset #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cbo_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cbo_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [cbo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbo_pkg::DIM_W-1:0]           csr_data
);
   import cbo_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   dims_type         dims;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   // register writes; indexes beyond the list are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && (csr_index == CSR_WINDOW_WIDTH))  width_in  = csr_data;
      if (csr_write && (csr_index == CSR_WINDOW_HEIGHT)) height_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WINDOW_WIDTH_RESET;
         height_ff <= WINDOW_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign dims.width  = width_ff;
   assign dims.height = height_ff;

   cbo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   cbo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   cbo_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_data),
      .job_pop   (pop_ready),
      .dims      (dims),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for camera_basis_from_offset.
// Depends on cbo_pkg and the RTL of the block; predicts each five-item run in-bench.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cbo_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int RUN_LIMIT = 1000000;   // cycles before declaring a hang
   localparam int LONG_HOLD = 600;       // receiver hold-off, long enough to fill the block
   localparam int SETTLE    = 300;       // covers one back-end pass

   typedef longint signed vec3_type [0:2];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_WINDOW_WIDTH;
   logic [DIM_W-1:0] csr_data = '0;

   // bench copy of the window registers
   logic [DIM_W-1:0] win_width  = WINDOW_WIDTH_RESET;
   logic [DIM_W-1:0] win_height = WINDOW_HEIGHT_RESET;

   rsp_type basis_expected [$];   // pending basis vectors, oldest first
   int   error_count = 0;
   int   cycle_count = 0;
   bit   idle_enable = 1'b1;      // random gaps/stalls on both sides
   bit   hold_request = 1'b0;     // asks the stall process for one long hold-off

   camera_basis_from_offset #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   // floor of the square root, bit by bit
   function automatic longint unsigned root_floor(input longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // fixed-point unit vector; zero in, zero out
   function automatic void unit_vector(input vec3_type a, output vec3_type u);
      longint unsigned mag [0:2];
      bit neg [0:2];
      longint unsigned m, r, q;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = a[i] < 0;
         mag[i] = neg[i] ? longint'(-a[i]) : longint'(a[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      // bring the largest magnitude into [2^30, 2^31)
      while (m >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         m = m << 1;
      end
      r = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] << FRAC_BITS) / r;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic logic signed [COMP_W-1:0] clamp32(input longint signed v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[COMP_W-1:0];
   endfunction

   function automatic rsp_type basis_item(input logic [VEC_ID_W-1:0] id,
                                          input vec3_type c, input bit degen);
      rsp_type o;
      o.vector_id  = id;
      o.comp_x     = clamp32(c[0]);
      o.comp_y     = clamp32(c[1]);
      o.comp_z     = clamp32(c[2]);
      o.degenerate = degen;
      o.last       = (id == VEC_BACK);
      return o;
   endfunction

   // queue the five vectors one offset must produce
   task automatic predict_basis(input req_type r);
      vec3_type v, t, near_u, right_u, left_u, up_u, back_u, zero;
      longint signed w, h;
      v[0] = r.offset_x;
      v[1] = r.offset_y;
      v[2] = r.offset_z;
      zero[0] = 0; zero[1] = 0; zero[2] = 0;
      if (v[0] == 0 && v[1] == 0) begin
         // offset on the z axis (or zero): flagged, zero vectors
         basis_expected.push_back(basis_item(VEC_NEAR,  zero, 1'b1));
         basis_expected.push_back(basis_item(VEC_RIGHT, zero, 1'b1));
         basis_expected.push_back(basis_item(VEC_LEFT,  zero, 1'b1));
         basis_expected.push_back(basis_item(VEC_UP,    zero, 1'b1));
         basis_expected.push_back(basis_item(VEC_BACK,  zero, 1'b1));
         return;
      end
      for (int i = 0; i < 3; i++) t[i] = -v[i];
      unit_vector(t, near_u);
      t[0] = -v[1];
      t[1] = v[0];
      t[2] = 0;
      unit_vector(t, right_u);
      for (int i = 0; i < 3; i++) left_u[i] = -right_u[i];
      t[0] = right_u[1] * near_u[2] - right_u[2] * near_u[1];
      t[1] = right_u[2] * near_u[0] - right_u[0] * near_u[2];
      t[2] = right_u[0] * near_u[1] - right_u[1] * near_u[0];
      unit_vector(t, up_u);
      w = (win_width == 0) ? 1 : longint'(win_width);   // zero width acts as one
      h = longint'(win_height);
      for (int i = 0; i < 3; i++) begin
         up_u[i]   = up_u[i] * h / w;   // truncates toward zero
         back_u[i] = -up_u[i];
      end
      basis_expected.push_back(basis_item(VEC_NEAR,  near_u,  1'b0));
      basis_expected.push_back(basis_item(VEC_RIGHT, right_u, 1'b0));
      basis_expected.push_back(basis_item(VEC_LEFT,  left_u,  1'b0));
      basis_expected.push_back(basis_item(VEC_UP,    up_u,    1'b0));
      basis_expected.push_back(basis_item(VEC_BACK,  back_u,  1'b0));
   endtask

   // ---------------- result side ----------------

   // receiver stall pattern; one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare every accepted item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (basis_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item %h", $time, rsp_data);
         end else begin
            want = basis_expected.pop_front();
            if (rsp_data.vector_id !== want.vector_id) begin
               error_count++;
               $display("%0t: vector_id exp %0d got %0d", $time, want.vector_id,
                        rsp_data.vector_id);
            end
            if (rsp_data.comp_x !== want.comp_x) begin
               error_count++;
               $display("%0t: comp_x exp %0d got %0d", $time, want.comp_x, rsp_data.comp_x);
            end
            if (rsp_data.comp_y !== want.comp_y) begin
               error_count++;
               $display("%0t: comp_y exp %0d got %0d", $time, want.comp_y, rsp_data.comp_y);
            end
            if (rsp_data.comp_z !== want.comp_z) begin
               error_count++;
               $display("%0t: comp_z exp %0d got %0d", $time, want.comp_z, rsp_data.comp_z);
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               error_count++;
               $display("%0t: degenerate exp %0b got %0b", $time, want.degenerate,
                        rsp_data.degenerate);
            end
            if (rsp_data.last !== want.last) begin
               error_count++;
               $display("%0t: last exp %0b got %0b", $time, want.last, rsp_data.last);
            end
         end
      end
   end

   // ---------------- request side ----------------

   function automatic int gap_cycles();
      int p;
      if (!idle_enable) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 94) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // called and returns at a rising edge; valid stays high across back-to-back items
   task automatic send_offset(input req_type r, input bit no_gap = 1'b0);
      int g;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_basis(r);
      g = no_gap ? 0 : gap_cycles();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      req_type r;
      r.offset_x = x;
      r.offset_y = y;
      r.offset_z = z;
      send_offset(r);
   endtask

   // wait out every pending vector, then let the back end go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (basis_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write; only called after drain()
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_WINDOW_WIDTH:  win_width  = val;
         CSR_WINDOW_HEIGHT: win_height = val;
         default: ;   // unused indexes are ignored
      endcase
   endtask

   function automatic logic [31:0] pick_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
         4, 5: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type pick_offset();
      req_type r;
      r.offset_x = pick_comp();
      r.offset_y = pick_comp();
      r.offset_z = pick_comp();
      if ($urandom_range(0, 9) == 0) begin   // on the z axis
         r.offset_x = '0;
         r.offset_y = '0;
      end
      return r;
   endfunction

   // ---------------- tests ----------------

   task automatic test_directed();
      send_xyz(32'h0, 32'h0, 32'h0);                      // zero offset
      send_xyz(32'h0, 32'h0, 32'h7fff_ffff);              // parallel to z
      send_xyz(32'h0, 32'h0, 32'h8000_0000);
      send_xyz(32'h0001_0000, 32'h0, 32'h0);              // unit axes
      send_xyz(32'h0, 32'h0001_0000, 32'h0);
      send_xyz(32'h0, 32'h0, 32'h0001_0000);
      send_xyz(32'h1, 32'h0, 32'h0);                      // smallest nonzero
      send_xyz(32'h0, 32'hffff_ffff, 32'h1);
      send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_xyz(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_xyz(32'h8000_0000, 32'h0, 32'h0);
      send_xyz(32'h0, 32'h8000_0000, 32'h7fff_ffff);
      send_xyz(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_xyz(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_xyz(32'h0003_0000, 32'hfffc_0000, 32'h0005_0000);
      send_xyz(32'h1, 32'h1, 32'h7fff_ffff);              // nearly on z
      send_xyz(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
      drain();
   endtask

   // aspect settings, extremes included; each followed by a few offsets
   task automatic test_window_regs();
      logic [DIM_W-1:0] widths  [0:6] = '{14'd1, 14'd8192, 14'd0, 14'd1024, 14'd3, 14'h3fff, 14'd1};
      logic [DIM_W-1:0] heights [0:6] = '{14'd8192, 14'd1, 14'd768, 14'd0, 14'd7, 14'h3fff, 14'd1};
      for (int s = 0; s < 7; s++) begin
         write_reg(CSR_WINDOW_WIDTH, widths[s]);
         write_reg(CSR_WINDOW_HEIGHT, heights[s]);
         write_reg(2'd2, 14'($urandom));   // out-of-range index must not land
         write_reg(2'd3, 14'($urandom));
         repeat (7) send_offset(pick_offset());
         drain();
      end
      write_reg(CSR_WINDOW_WIDTH, 14'd1920);
      write_reg(CSR_WINDOW_HEIGHT, 14'd1080);
   endtask

   // receiver holds off while offsets keep coming, so the input backs up
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (10) send_offset(pick_offset(), 1'b1);
      drain();
   endtask

   // no idling at all, then sender waits for every vector before resuming
   task automatic test_quiet_then_pause();
      idle_enable = 1'b0;
      repeat (12) send_offset(pick_offset(), 1'b1);
      req_valid <= 1'b0;
      while (basis_expected.size() != 0) @(posedge clock);
      idle_enable = 1'b1;
      repeat (8) send_offset(pick_offset());
      drain();
   endtask

   task automatic test_random();
      for (int n = 0; n < 300; n++) begin
         send_offset(pick_offset());
         if (n == 150) begin   // mid-run aspect change
            drain();
            write_reg(CSR_WINDOW_WIDTH, 14'($urandom_range(1, 8192)));
            write_reg(CSR_WINDOW_HEIGHT, 14'($urandom_range(0, 8192)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_window_regs();
      test_backpressure();
      test_quiet_then_pause();
      test_random();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
